[sv/bfsa_pkg.sv]
// ----------------------------------------------------------------------------
// bfsa_pkg
// Field widths and operation codes for the bit field stream access block.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 13;
  localparam int LEN_W = 7;
  localparam int VAL_W = 64;
  localparam int CUR_W = 14;

  localparam logic [LEN_W-1:0] MAX_FIELD = 7'd64;

  localparam logic [OP_W-1:0] OP_READ_POS  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_POS = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_CUR  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_CUR = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_CUR   = 3'd4;

endpackage

[sv/bfsa_if.sv]
// ----------------------------------------------------------------------------
// bfsa_if
// Request and result channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface bfsa_in_if import bfsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] bit_position;
  logic [LEN_W-1:0] field_length;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, operation, bit_position, field_length, write_value,
                  input ready);
  modport sink   (input valid, operation, bit_position, field_length, write_value,
                  output ready);
endinterface

interface bfsa_out_if import bfsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic             range_error;

  modport source (output valid, read_value, range_error, input ready);
  modport sink   (input valid, read_value, range_error, output ready);
endinterface

[sv/bit_field_stream_access_top.sv]
// ----------------------------------------------------------------------------
// bit_field_stream_access_top
// MSB-first bit field read/write on a byte memory, with a stored bit cursor.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  operation, bit_position, field_length, write_value
//   out_ch   out  valid/ready  read_value, range_error
//
// Requests are taken only in idle, one at a time. A field touches n = 1..9
// bytes, read and written one byte per cycle through one byte-wide read port
// and one write port. Set cursor, zero length, errors and unused codes skip it.
// After reset a clearing pass zeroes the memory byte by byte; no request is
// taken meanwhile. A result waits in the output register while the next
// request is already accepted and processed.
// ----------------------------------------------------------------------------
module bit_field_stream_access_top import bfsa_pkg::*; #(
  parameter int MEM_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bfsa_in_if.sink     in_ch,
  bfsa_out_if.source  out_ch
);

  localparam int AW       = $clog2(MEM_BYTES);
  localparam int MEM_BITS = MEM_BYTES * 8;
  localparam int MBW      = $clog2(MEM_BITS + 1);
  localparam int SW       = (MBW > CUR_W + 1) ? MBW : CUR_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_ACCESS,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    ret_addr_r;
  logic [OP_W-1:0]  op_r;
  logic [LEN_W-1:0] len_r;
  logic [VAL_W-1:0] val_r;
  logic [CUR_W-1:0] start_r;
  logic [CUR_W-1:0] cur_r;
  logic             wr_r;
  logic             rdres_r;
  logic             err_r;
  logic             adv_r;
  logic [3:0]       n_r;
  logic [3:0]       cnt_r;
  logic             rv_r;
  logic [2:0]       tail_r;
  logic [VAL_W-1:0] mask_r;
  logic [71:0]      wmask_r;
  logic [71:0]      wdata_r;
  logic [71:0]      win_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_rv_r;
  logic             out_err_r;

  logic [7:0]       mem [MEM_BYTES];
  logic [7:0]       rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;

  logic             in_acc;
  logic             issue;
  logic [SW-1:0]    end_bit;
  logic             fits;
  logic             is_mem;
  logic             is_rd;
  logic             at_cur;
  logic [6:0]       sum_ol;
  logic [6:0]       sh;
  logic [VAL_W-1:0] mask64;
  logic [7:0]       wr_byte;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.range_error = out_err_r;

  // Setup-cycle decode
  always_comb begin
    is_mem  = (op_r == OP_READ_POS) || (op_r == OP_WRITE_POS) ||
              (op_r == OP_READ_CUR) || (op_r == OP_WRITE_CUR);
    is_rd   = (op_r == OP_READ_POS) || (op_r == OP_READ_CUR);
    at_cur  = (op_r == OP_READ_CUR) || (op_r == OP_WRITE_CUR);
    end_bit = SW'(start_r) + SW'(len_r);
    fits    = (len_r <= MAX_FIELD) && (end_bit <= SW'(MEM_BITS));
    sum_ol  = 7'(start_r[2:0]) + len_r;
    sh      = 7'd72 - sum_ol;
    mask64  = len_r[6] ? '1 : ((64'd1 << len_r[5:0]) - 64'd1);
  end

  assign issue   = (state_r == S_ACCESS) && (cnt_r != n_r);
  assign wr_byte = (rdata_r & ~wmask_r[71:64]) | wdata_r[71:64];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ret_addr_r;
    mem_wdata = wr_byte;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_ACCESS && rv_r && wr_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MEM_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_ch.operation;
            len_r <= in_ch.field_length;
            val_r <= in_ch.write_value;
            if (in_ch.operation == OP_READ_CUR || in_ch.operation == OP_WRITE_CUR) begin
              start_r <= cur_r;
            end else begin
              start_r <= CUR_W'(in_ch.bit_position);
            end
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          wr_r    <= !is_rd;
          rdres_r <= is_mem && is_rd && fits && (len_r != '0);
          err_r   <= is_mem && !fits;
          adv_r   <= at_cur && fits;
          n_r     <= 4'((8'(sum_ol) + 8'd7) >> 3);
          cnt_r   <= '0;
          rv_r    <= 1'b0;
          tail_r  <= 3'(3'd0 - sum_ol[2:0]);
          mask_r  <= mask64;
          wmask_r <= {8'd0, mask64} << sh;
          wdata_r <= {8'd0, val_r & mask64} << sh;
          addr_r  <= AW'(start_r[CUR_W-1:3]);
          if (op_r == OP_SET_CUR) begin
            cur_r <= start_r;
          end
          if (is_mem && fits && (len_r != '0)) begin
            state_r <= S_ACCESS;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_ACCESS: begin
          rv_r       <= issue;
          ret_addr_r <= addr_r;
          if (issue) begin
            addr_r <= addr_r + AW'(1);
            cnt_r  <= cnt_r + 4'd1;
          end
          if (rv_r) begin
            win_r   <= {win_r[63:0], rdata_r};
            wmask_r <= {wmask_r[63:0], 8'd0};
            wdata_r <= {wdata_r[63:0], 8'd0};
            if (!issue) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_err_r   <= err_r;
            out_rv_r    <= rdres_r ? (VAL_W'(win_r >> tail_r) & mask_r) : '0;
            if (adv_r) begin
              cur_r <= cur_r + CUR_W'(len_r);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SETUP))
    else $error("accepted request did not enter setup");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) |-> (cnt_r <= n_r) && (n_r <= 4'd9))
    else $error("byte reads exceed field span");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_rv_r == '0))
    else $error("range error result carries data");

  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_SETUP || state_r == S_DONE) |=> $stable(cur_r))
    else $error("cursor moved outside setup/done");

endmodule

[tb/bit_field_stream_access_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_stream_access_top_tb
// Self-checking bench for the MSB-first bit field block. Requests go in on
// the in_ch channel and results come out on out_ch. Both channels idle in
// random bursts. A scoreboard keeps its own copy of the byte memory and the
// bit cursor, and predicts each result from the accepted requests. Results
// are checked in order, field by field. A short directed sweep covers the
// edge cases. Random traffic follows, with cursor runs, range errors and
// unused codes mixed in.
// ----------------------------------------------------------------------------
module bit_field_stream_access_top_tb import bfsa_pkg::*; ();

  localparam int MEM_BYTES       = 1024;
  localparam int BITS_PER_BYTE   = 8;
  localparam int LAST_BIT        = 7;
  localparam int MEM_BITS        = MEM_BYTES * BITS_PER_BYTE;
  localparam int RANDOM_REQUESTS = 950;
  localparam int CALM_REQUESTS   = 150;
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic             range_error;
  } field_result_t;

  class bit_field_scoreboard;
    logic [BITS_PER_BYTE-1:0] mem_bytes [MEM_BYTES];
    logic [CUR_W-1:0]         cursor;
    field_result_t            pending_results [$];
    int                       fail_count;

    function new();
      foreach (mem_bytes[i]) mem_bytes[i] = '0;
      cursor     = '0;
      fail_count = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [LEN_W-1:0] len, logic [VAL_W-1:0] val);
      field_result_t res;
      bit            at_cursor;
      bit            is_write;
      int unsigned   start;
      int unsigned   p;
      res.read_value  = '0;
      res.range_error = 1'b0;
      if (op == OP_SET_CUR) begin
        cursor = CUR_W'(pos);
      end else if (op == OP_READ_POS || op == OP_WRITE_POS ||
                   op == OP_READ_CUR || op == OP_WRITE_CUR) begin
        at_cursor = (op == OP_READ_CUR || op == OP_WRITE_CUR);
        is_write  = (op == OP_WRITE_POS || op == OP_WRITE_CUR);
        start     = at_cursor ? int'(cursor) : int'(pos);
        if (len > MAX_FIELD || start + len > MEM_BITS) begin
          res.range_error = 1'b1;
        end else begin
          for (int i = 0; i < len; i++) begin
            p = start + i;
            if (is_write)
              mem_bytes[p / BITS_PER_BYTE][LAST_BIT - (p % BITS_PER_BYTE)] = val[len - 1 - i];
            else
              res.read_value = {res.read_value[VAL_W-2:0],
                                mem_bytes[p / BITS_PER_BYTE][LAST_BIT - (p % BITS_PER_BYTE)]};
          end
          if (at_cursor) cursor = cursor + CUR_W'(len);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [VAL_W-1:0] read_value, logic range_error);
      field_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: read_value=%h range_error=%b",
               read_value, range_error);
        fail_count++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (read_value !== exp_res.read_value) begin
        $error("read_value: expected %h, actual %h", exp_res.read_value, read_value);
        fail_count++;
      end
      if (range_error !== exp_res.range_error) begin
        $error("range_error: expected %b, actual %b", exp_res.range_error, range_error);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bfsa_in_if  in_ch ();
  bfsa_out_if out_ch ();

  bit_field_stream_access_top #(.MEM_BYTES(MEM_BYTES)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bit_field_scoreboard sb;
  bit                  calm;
  int                  stall_left;
  int                  random_sent;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("bit_field_stream_access_top_tb failed");
    $finish;
  end

  // result side: random stall bursts, none once calm
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
      stall_left   = 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   = stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   = $urandom_range(1, 13) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.read_value, out_ch.range_error);
  end

  // entered and left at a falling edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] val);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.bit_position = pos;
    in_ch.field_length = len;
    in_ch.write_value  = val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(op, pos, len, val);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return POS_W'($urandom_range(0, 511));
    if (r < 9) return POS_W'($urandom);
    return POS_W'(MEM_BITS - 1 - $urandom_range(0, 80));
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return MAX_FIELD;
    return LEN_W'($urandom_range(1, 64));
  endfunction

  initial begin
    int kind;
    int run_len;
    bit drained_mid;

    sb                 = new();
    calm               = 1'b0;
    drained_mid        = 1'b0;
    random_sent        = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_READ_POS;
    in_ch.bit_position = '0;
    in_ch.field_length = '0;
    in_ch.write_value  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(OP_READ_POS,  13'd0,    7'd64,  '0);
    send_request(OP_WRITE_POS, 13'd0,    7'd64,  '1);
    send_request(OP_READ_POS,  13'd0,    7'd64,  '0);
    send_request(OP_WRITE_POS, 13'd3,    7'd5,   '0);
    send_request(OP_READ_POS,  13'd0,    7'd8,   '0);
    send_request(OP_WRITE_POS, 13'd8191, 7'd1,   64'd1);
    send_request(OP_READ_POS,  13'd8191, 7'd1,   '0);
    send_request(OP_READ_POS,  13'd8128, 7'd64,  '0);
    send_request(OP_READ_POS,  13'd8129, 7'd64,  '0);
    send_request(OP_WRITE_POS, 13'd8190, 7'd3,   '1);
    send_request(OP_READ_POS,  13'd0,    7'd0,   '0);
    send_request(OP_WRITE_POS, 13'd100,  7'd0,   '1);
    send_request(OP_READ_POS,  13'd96,   7'd16,  '0);
    send_request(OP_READ_POS,  13'd5,    7'd65,  '0);
    send_request(OP_WRITE_POS, 13'd0,    7'd127, '0);
    send_request(OP_WRITE_POS, 13'd77,   7'd64,  64'hA5C3_0F96_5A3C_F069);
    send_request(OP_READ_POS,  13'd72,   7'd64,  '0);
    send_request(OP_SET_CUR,   13'd8180, 7'd0,   '0);
    send_request(OP_READ_CUR,  13'd0,    7'd12,  '0);
    send_request(OP_READ_CUR,  13'd0,    7'd1,   '0);
    send_request(OP_WRITE_CUR, 13'd0,    7'd0,   '1);
    send_request(OP_SET_CUR,   13'd40,   7'd0,   '0);
    send_request(OP_WRITE_CUR, 13'd0,    7'd20,  64'h0_0000_0000_000B_EEF1);
    send_request(OP_READ_CUR,  13'd0,    7'd64,  '0);
    send_request(OP_UNUSED_LO,  13'd1,   7'd8,   '1);
    send_request(OP_UNUSED_MID, 13'd2,   7'd8,   '1);
    send_request(OP_UNUSED_HI,  13'd3,   7'd8,   '1);

    drain_results();
    @(negedge clk);

    while (random_sent < RANDOM_REQUESTS) begin
      calm = (random_sent >= RANDOM_REQUESTS - CALM_REQUESTS);
      if (!drained_mid && random_sent >= RANDOM_REQUESTS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // cursor run: load, then a string of cursor reads and writes
        if ($urandom_range(0, 4) == 0)
          send_request(OP_SET_CUR, POS_W'(MEM_BITS - $urandom_range(1, 200)), '0, '0);
        else
          send_request(OP_SET_CUR, pick_position(), '0, '0);
        random_sent++;
        run_len = $urandom_range(2, 8);
        repeat (run_len) begin
          send_request($urandom_range(0, 1) ? OP_WRITE_CUR : OP_READ_CUR, POS_W'($urandom),
                       pick_length(), {$urandom, $urandom});
          random_sent++;
        end
      end else if (kind < 19) begin
        send_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), POS_W'($urandom),
                     LEN_W'($urandom), {$urandom, $urandom});
        random_sent++;
      end else if (kind < 23) begin
        send_request(OP_W'($urandom_range(OP_READ_POS, OP_WRITE_CUR)), pick_position(),
                     LEN_W'($urandom_range(65, 127)), {$urandom, $urandom});
        random_sent++;
      end else begin
        send_request(OP_W'($urandom_range(OP_READ_POS, OP_SET_CUR)), pick_position(),
                     pick_length(), {$urandom, $urandom});
        random_sent++;
      end
    end

    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("bit_field_stream_access_top_tb passed");
    end else begin
      $display("bit_field_stream_access_top_tb failed");
    end
    $finish;
  end

endmodule
